/* hw/rtl/i2c_master_bit_engine_core_macros.svh */
// Assertion macros shared by the I2C bit engine checker.
`ifndef I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IBE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IBE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ibe_pkg.sv */
// Shared types and constants for the I2C master bit engine.
package ibe_pkg;

    localparam int BYTE_BITS  = 8;
    localparam int KIND_W     = 3;
    localparam int UNIT_W     = 10;
    localparam int LIMIT_W    = 8;
    localparam int WAIT_W     = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 16;

    // command kinds
    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STOP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ACK   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_NACK  = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RSVD  = 3'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_LIMIT  = 2'd1;

    // one classified tick as it travels from front to back
    typedef struct packed {
        logic                 is_cmd;
        logic [KIND_W-1:0]    kind;
        logic [BYTE_BITS-1:0] wdata;
        logic                 sda;
    } t_item;

endpackage

/* hw/rtl/ibe_front.sv */
// Front end: takes input ticks, unpacks and classifies the command kind.
module ibe_front (
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [ibe_pkg::S_DATA_W-1:0]   i_s_tdata,
    input  logic [ibe_pkg::KIND_W-1:0]     i_s_tuser,
    input  logic                           i_q_full,
    output logic                           o_push,
    output ibe_pkg::t_item                 o_item
);
    import ibe_pkg::*;

    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;

    always_comb begin
        o_item.kind   = i_s_tuser;
        o_item.wdata  = i_s_tdata[BYTE_BITS-1:0];
        o_item.sda    = i_s_tdata[BYTE_BITS];
        // no-op and reserved kinds only tick the sequencer
        o_item.is_cmd = (i_s_tuser != KIND_NONE) && (i_s_tuser != KIND_RSVD);
    end

endmodule

/* hw/rtl/ibe_queue.sv */
// Two-entry queue between front end and sequencer.
module ibe_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ibe_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ibe_pkg::t_item o_item
);
    import ibe_pkg::*;

    t_item       r_mem [0:1];
    logic        r_wp, n_wp;
    logic        r_rp, n_rp;
    logic [1:0]  r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_comb begin
        n_wp  = i_push ? ~r_wp : r_wp;
        n_rp  = i_pop  ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

/* hw/rtl/ibe_back.sv */
// Back end: SCL/SDA phase sequencer and registered result stage.
module ibe_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  ibe_pkg::t_item                i_item,
    output logic                          o_pop,
    input  logic [ibe_pkg::UNIT_W-1:0]    i_unit_ticks,
    input  logic [ibe_pkg::LIMIT_W-1:0]   i_poll_limit,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [ibe_pkg::M_DATA_W-1:0]  o_m_tdata
);
    import ibe_pkg::*;

    localparam logic [4:0] PH_IDLE = 5'd0;
    localparam logic [4:0] PH_ST0  = 5'd1;
    localparam logic [4:0] PH_ST1  = 5'd2;
    localparam logic [4:0] PH_ST2  = 5'd3;
    localparam logic [4:0] PH_ST3  = 5'd4;
    localparam logic [4:0] PH_SP0  = 5'd5;
    localparam logic [4:0] PH_SP1  = 5'd6;
    localparam logic [4:0] PH_WR0  = 5'd7;
    localparam logic [4:0] PH_WR1  = 5'd8;
    localparam logic [4:0] PH_WR2  = 5'd9;
    localparam logic [4:0] PH_RD0  = 5'd10;
    localparam logic [4:0] PH_RD1  = 5'd11;
    localparam logic [4:0] PH_AK0  = 5'd12;
    localparam logic [4:0] PH_AK1  = 5'd13;
    localparam logic [4:0] PH_NK0  = 5'd14;
    localparam logic [4:0] PH_NK1  = 5'd15;
    localparam logic [4:0] PH_NK2  = 5'd16;

    logic [4:0]           r_phase, n_phase;
    logic [3:0]           r_bits,  n_bits;
    logic [WAIT_W-1:0]    r_wait,  n_wait;
    logic [LIMIT_W-1:0]   r_poll,  n_poll;
    logic [BYTE_BITS-1:0] r_shift, n_shift;
    logic                 r_scl,   n_scl;
    logic                 r_sda,   n_sda;
    logic                 r_ack,   n_ack;
    logic [BYTE_BITS-1:0] r_rx,    n_rx;
    logic                 r_ovalid;
    logic [M_DATA_W-1:0]  r_odata;

    logic                 step;
    logic                 done;
    logic [WAIT_W-1:0]    unit, w2, w5, w10, wdec;
    logic [LIMIT_W-1:0]   lim;
    logic [3:0]           bits_inc;
    logic [BYTE_BITS-1:0] shift_l;

    assign step  = i_q_valid && (!r_ovalid || i_m_tready);
    assign o_pop = step;

    // wait lengths of 2, 5 and 10 units by shifts and adds
    always_comb begin
        unit = (i_unit_ticks == '0) ? WAIT_W'(1) : WAIT_W'(i_unit_ticks);
        w2   = unit << 1;
        w5   = (unit << 2) + unit;
        w10  = w5 << 1;
        lim  = (i_poll_limit == '0) ? LIMIT_W'(1) : i_poll_limit;
        wdec = (r_wait != '0) ? r_wait - WAIT_W'(1) : '0;
        bits_inc = r_bits + 4'd1;
        shift_l  = {r_shift[BYTE_BITS-2:0], 1'b0};
    end

    always_comb begin
        n_phase = r_phase;
        n_bits  = r_bits;
        n_wait  = r_wait;
        n_poll  = r_poll;
        n_shift = r_shift;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_ack   = r_ack;
        n_rx    = r_rx;
        done    = 1'b0;
        if (step) begin
            if (r_phase == PH_IDLE) begin
                if (i_item.is_cmd) begin
                    n_bits = '0;
                    n_poll = '0;
                    unique case (i_item.kind)
                        KIND_START: begin
                            n_phase = PH_ST0;
                            n_wait  = w5;
                        end
                        KIND_STOP: begin
                            n_sda   = 1'b0;
                            n_scl   = 1'b1;
                            n_phase = PH_SP0;
                            n_wait  = w5;
                        end
                        KIND_WRITE: begin
                            n_shift = i_item.wdata;
                            n_sda   = i_item.wdata[BYTE_BITS-1];
                            n_phase = PH_WR0;
                            n_wait  = w2;
                        end
                        KIND_READ: begin
                            n_shift = '1;
                            n_sda   = 1'b1;
                            n_scl   = 1'b1;
                            n_phase = PH_RD0;
                            n_wait  = w2;
                        end
                        KIND_ACK: begin
                            n_sda   = 1'b1;
                            n_phase = PH_AK0;
                            n_wait  = w2;
                        end
                        KIND_NACK: begin
                            n_sda   = 1'b1;
                            n_phase = PH_NK0;
                            n_wait  = w2;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end else begin
                n_wait = wdec;
                if (wdec == '0) begin
                    unique case (r_phase)
                        PH_ST0: begin
                            n_sda = 1'b1; n_scl = 1'b1;
                            n_phase = PH_ST1; n_wait = w10;
                        end
                        PH_ST1: begin
                            n_sda = 1'b0; n_phase = PH_ST2; n_wait = w10;
                        end
                        PH_ST2: begin
                            n_scl = 1'b0; n_phase = PH_ST3; n_wait = w10;
                        end
                        PH_SP0: begin
                            n_sda = 1'b1; n_phase = PH_SP1; n_wait = w5;
                        end
                        PH_WR0: begin
                            n_scl = 1'b1; n_phase = PH_WR1; n_wait = w2;
                        end
                        PH_WR1: begin
                            n_scl = 1'b0; n_phase = PH_WR2; n_wait = w2;
                        end
                        PH_WR2: begin
                            n_shift = shift_l;
                            n_bits  = bits_inc;
                            if (bits_inc >= 4'(BYTE_BITS)) begin
                                n_sda = 1'b1;
                                done  = 1'b1;
                            end else begin
                                n_sda   = shift_l[BYTE_BITS-1];
                                n_phase = PH_WR0;
                                n_wait  = w2;
                            end
                        end
                        PH_RD0: begin
                            n_shift = {r_shift[BYTE_BITS-2:0], i_item.sda};
                            n_scl   = 1'b0;
                            n_phase = PH_RD1;
                            n_wait  = w2;
                        end
                        PH_RD1: begin
                            n_bits = bits_inc;
                            if (bits_inc >= 4'(BYTE_BITS)) begin
                                n_rx = r_shift;
                                done = 1'b1;
                            end else begin
                                n_scl = 1'b1; n_phase = PH_RD0; n_wait = w2;
                            end
                        end
                        PH_AK0: begin
                            n_scl = 1'b1; n_poll = LIMIT_W'(1);
                            n_phase = PH_AK1; n_wait = w2;
                        end
                        PH_AK1: begin
                            if (!i_item.sda) begin
                                n_scl = 1'b0; n_ack = 1'b0; done = 1'b1;
                            end else if (r_poll >= lim) begin
                                n_scl = 1'b0; n_ack = 1'b1; done = 1'b1;
                            end else begin
                                n_poll = r_poll + LIMIT_W'(1);
                                n_wait = w2;
                            end
                        end
                        PH_NK0: begin
                            n_scl = 1'b1; n_phase = PH_NK1; n_wait = w2;
                        end
                        PH_NK1: begin
                            n_scl = 1'b0; n_phase = PH_NK2; n_wait = w2;
                        end
                        PH_NK2: begin
                            n_sda = 1'b1; done = 1'b1;
                        end
                        default: begin
                            // last step of start/stop, or an unknown phase
                            done = 1'b1;
                        end
                    endcase
                    if (done) begin
                        n_phase = PH_IDLE;
                        n_wait  = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_bits   <= '0;
            r_wait   <= '0;
            r_poll   <= '0;
            r_shift  <= '0;
            r_scl    <= 1'b1;
            r_sda    <= 1'b1;
            r_ack    <= 1'b0;
            r_rx     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_wait  <= n_wait;
            r_poll  <= n_poll;
            r_shift <= n_shift;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_ack   <= n_ack;
            r_rx    <= n_rx;
            if (step) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // result word: scl, sda, busy, done, read byte, ack missing, zero pad
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_odata <= {3'b000, n_ack, n_rx, done, (n_phase != PH_IDLE), n_sda, n_scl};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

endmodule

/* hw/rtl/i2c_master_bit_engine_core.sv */
// I2C master bit engine: top level with configuration registers.
//
// Each input transaction is one tick of the I2C pin sequencer; it carries the
// sampled SDA level and an optional command in tuser (none, start, stop,
// write byte, read byte, ACK check, NACK send). Every input transaction
// yields exactly one output transaction holding the SCL/SDA drive levels after
// that tick, busy and done flags, the last byte read and the ACK-missing flag.
// Commands given while busy (including on the done tick) are dropped. Pin
// waits are 2, 5 or 10 units of unit_ticks ticks each (0 acts as 1); the ACK
// check samples SDA every 2 units up to ack_poll_limit times (0 acts as 1).
// The block takes one transaction per clock while the result side is not
// stalled; the sequencer updates its whole state on each tick. An accepted
// tick is first written into the queue and is then registered into the
// result stage once the result side can take it. A two-entry queue
// between the front end and the sequencer, plus the result register, lets
// each side stall on its own. The configuration port is always ready and must
// only be written while the engine is idle with no ticks in flight.
module i2c_master_bit_engine_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [ibe_pkg::S_DATA_W-1:0]        i_s_tdata,  // [7:0] write_data, [8] sda_in
    input  logic [ibe_pkg::KIND_W-1:0]          i_s_tuser,  // [2:0] kind
    // result stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
    // [11:4] read_data, [12] ack_missing
    output logic [ibe_pkg::M_DATA_W-1:0]        o_m_tdata,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ibe_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ibe_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ibe_pkg::*;

    logic [UNIT_W-1:0]  r_unit_ticks;
    logic [LIMIT_W-1:0] r_poll_limit;

    logic  q_full, q_valid, push, pop;
    t_item front_item, q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks <= UNIT_W'(10);
            r_poll_limit <= LIMIT_W'(200);
        end else if (i_cfg_valid) begin
            // unknown indexes are ignored
            if (i_cfg_index == CFG_UNIT_TICKS) begin
                r_unit_ticks <= i_cfg_data[UNIT_W-1:0];
            end else if (i_cfg_index == CFG_ACK_LIMIT) begin
                r_poll_limit <= i_cfg_data[LIMIT_W-1:0];
            end
        end
    end

    ibe_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_item     (front_item)
    );

    ibe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    ibe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_item       (q_item),
        .o_pop        (pop),
        .i_unit_ticks (r_unit_ticks),
        .i_poll_limit (r_poll_limit),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata)
    );

endmodule

/* hw/rtl/ibe_checker.sv */
// Port-level checker for the I2C bit engine, bound to the top level.
`include "i2c_master_bit_engine_core_macros.svh"

module ibe_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           o_s_tready,
    input  logic [ibe_pkg::S_DATA_W-1:0]   i_s_tdata,
    input  logic [ibe_pkg::KIND_W-1:0]     i_s_tuser,
    input  logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [ibe_pkg::M_DATA_W-1:0]   o_m_tdata,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [ibe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ibe_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // stalled result holds
    `IBE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result changed while stalled")

    // a finishing tick always leaves the engine idle
    `IBE_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[3], !o_m_tdata[2], "done with busy set")

    // config writes never stall
    `IBE_ASSERT_IMP(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready, "config port stalled")

    // with the result side stalled and the queue full, input stays backed off while the stall lasts
    `IBE_ASSERT_NXT(a_in_backoff, i_clk, i_rst_n, o_m_tvalid && !i_m_tready && !o_s_tready, !o_s_tready || i_m_tready || !o_m_tvalid, "queue overran while stalled")

endmodule

bind i2c_master_bit_engine_core ibe_checker u_ibe_checker (.*);

/* bench/i2c_bit_engine_pin_checker.sv */
// Watches the I2C bit engine streams, predicts every pin transaction and compares it.
module i2c_bit_engine_pin_checker
    import ibe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [S_DATA_W-1:0]   i_s_tdata,
    input  logic [KIND_W-1:0]     i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_DATA_W-1:0]   i_m_tdata,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output logic                  o_engine_idle,
    output int                    o_cmd_count,
    output int                    o_result_count
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_ST3, PH_SP0, PH_SP1,
        PH_WR0, PH_WR1, PH_WR2, PH_RD0, PH_RD1, PH_AK0, PH_AK1,
        PH_NK0, PH_NK1, PH_NK2
    } seq_phase_e;

    // result layout, lowest bit last
    typedef struct packed {
        logic                 ack_missing;
        logic [BYTE_BITS-1:0] read_data;
        logic                 done;
        logic                 busy;
        logic                 sda;
        logic                 scl;
    } pin_result_t;

    pin_result_t          expected_pins[$];

    logic [UNIT_W-1:0]    unit_cfg;
    logic [LIMIT_W-1:0]   limit_cfg;
    seq_phase_e           seq_phase;
    logic [3:0]           bits_done;
    logic [WAIT_W-1:0]    wait_left;
    logic [7:0]           polls;
    logic [BYTE_BITS-1:0] shift_reg;
    logic [BYTE_BITS-1:0] rx_byte;
    logic                 scl_q;
    logic                 sda_q;
    logic                 ack_miss_q;
    logic                 cmd_done;
    int                   mismatches;
    int                   cmds_taken;
    int                   results_checked;

    assign o_fail_count   = mismatches;
    assign o_cmd_count    = cmds_taken;
    assign o_result_count = results_checked;

    task automatic load_wait(input int units);
        int ticks;
        ticks     = units * ((unit_cfg == '0) ? 1 : int'(unit_cfg));
        wait_left = ticks[WAIT_W-1:0];
    endtask

    task automatic enter(input seq_phase_e ph, input int units);
        seq_phase = ph;
        load_wait(units);
    endtask

    task automatic end_cmd();
        seq_phase = PH_IDLE;
        wait_left = '0;
        cmd_done  = 1'b1;
    endtask

    // one tick of the pin sequencer
    task automatic step_pin_sequencer(input logic [KIND_W-1:0] kind,
                                      input logic [BYTE_BITS-1:0] wdata,
                                      input logic sda, output pin_result_t res);
        logic [7:0] lim;
        lim      = (limit_cfg == '0) ? 8'd1 : limit_cfg;
        cmd_done = 1'b0;
        if (seq_phase == PH_IDLE) begin
            if (kind >= KIND_START && kind <= KIND_NACK) begin
                cmds_taken++;
                bits_done = '0;
                polls     = '0;
            end
            case (kind)
                KIND_START: enter(PH_ST0, 5);
                KIND_STOP: begin
                    sda_q = 1'b0;
                    scl_q = 1'b1;
                    enter(PH_SP0, 5);
                end
                KIND_WRITE: begin
                    shift_reg = wdata;
                    sda_q     = wdata[7];
                    enter(PH_WR0, 2);
                end
                KIND_READ: begin
                    shift_reg = 8'hFF;
                    sda_q     = 1'b1;
                    scl_q     = 1'b1;
                    enter(PH_RD0, 2);
                end
                KIND_ACK: begin
                    sda_q = 1'b1;
                    enter(PH_AK0, 2);
                end
                KIND_NACK: begin
                    sda_q = 1'b1;
                    enter(PH_NK0, 2);
                end
                default: ;
            endcase
        end else begin
            if (wait_left != '0) wait_left--;
            if (wait_left == '0) begin
                case (seq_phase)
                    PH_ST0: begin
                        sda_q = 1'b1;
                        scl_q = 1'b1;
                        enter(PH_ST1, 10);
                    end
                    PH_ST1: begin
                        sda_q = 1'b0;
                        enter(PH_ST2, 10);
                    end
                    PH_ST2: begin
                        scl_q = 1'b0;
                        enter(PH_ST3, 10);
                    end
                    PH_SP0: begin
                        sda_q = 1'b1;
                        enter(PH_SP1, 5);
                    end
                    PH_WR0: begin
                        scl_q = 1'b1;
                        enter(PH_WR1, 2);
                    end
                    PH_WR1: begin
                        scl_q = 1'b0;
                        enter(PH_WR2, 2);
                    end
                    PH_WR2: begin
                        shift_reg = {shift_reg[6:0], 1'b0};
                        bits_done++;
                        if (bits_done >= BYTE_BITS) begin
                            sda_q = 1'b1;
                            end_cmd();
                        end else begin
                            sda_q = shift_reg[7];
                            enter(PH_WR0, 2);
                        end
                    end
                    PH_RD0: begin
                        shift_reg = {shift_reg[6:0], sda};
                        scl_q     = 1'b0;
                        enter(PH_RD1, 2);
                    end
                    PH_RD1: begin
                        bits_done++;
                        if (bits_done >= BYTE_BITS) begin
                            rx_byte = shift_reg;
                            end_cmd();
                        end else begin
                            scl_q = 1'b1;
                            enter(PH_RD0, 2);
                        end
                    end
                    PH_AK0: begin
                        scl_q = 1'b1;
                        polls = 8'd1;
                        enter(PH_AK1, 2);
                    end
                    PH_AK1: begin
                        if (!sda) begin
                            scl_q      = 1'b0;
                            ack_miss_q = 1'b0;
                            end_cmd();
                        end else if (polls >= lim) begin
                            scl_q      = 1'b0;
                            ack_miss_q = 1'b1;
                            end_cmd();
                        end else begin
                            polls++;
                            load_wait(2);
                        end
                    end
                    PH_NK0: begin
                        scl_q = 1'b1;
                        enter(PH_NK1, 2);
                    end
                    PH_NK1: begin
                        scl_q = 1'b0;
                        enter(PH_NK2, 2);
                    end
                    PH_NK2: begin
                        sda_q = 1'b1;
                        end_cmd();
                    end
                    default: end_cmd();
                endcase
            end
        end
        res.scl         = scl_q;
        res.sda         = sda_q;
        res.busy        = (seq_phase != PH_IDLE);
        res.done        = cmd_done;
        res.read_data   = rx_byte;
        res.ack_missing = ack_miss_q;
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        pin_result_t want;
        pin_result_t got;
        if (!i_rst_n) begin
            expected_pins.delete();
            unit_cfg        = 10'd10;
            limit_cfg       = 8'd200;
            seq_phase       = PH_IDLE;
            bits_done       = '0;
            wait_left       = '0;
            polls           = '0;
            shift_reg       = '0;
            rx_byte         = '0;
            scl_q           = 1'b1;
            sda_q           = 1'b1;
            ack_miss_q      = 1'b0;
            cmd_done        = 1'b0;
            mismatches      = 0;
            cmds_taken      = 0;
            results_checked = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_UNIT_TICKS: unit_cfg  = i_cfg_data[UNIT_W-1:0];
                    CFG_ACK_LIMIT:  limit_cfg = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            // compare before predicting so a same-edge input can't mask an empty queue
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[$bits(pin_result_t)-1:0];
                if (expected_pins.size() == 0) begin
                    $display("%0t: unexpected result, expected nothing, got %0h",
                             $time, i_m_tdata);
                    mismatches++;
                end else begin
                    want = expected_pins.pop_front();
                    check_field("scl_out", want.scl, got.scl);
                    check_field("sda_out", want.sda, got.sda);
                    check_field("busy", want.busy, got.busy);
                    check_field("done", want.done, got.done);
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("ack_missing", want.ack_missing, got.ack_missing);
                    results_checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                step_pin_sequencer(i_s_tuser, i_s_tdata[7:0], i_s_tdata[8], want);
                expected_pins.push_back(want);
            end
        end
        o_pending     <= expected_pins.size();
        o_engine_idle <= (seq_phase == PH_IDLE);
    end

endmodule

/* bench/tb_i2c_master_bit_engine_core.sv */
// Testbench top for the I2C master bit engine: stimulus, stalls and verdict.
module tb_i2c_master_bit_engine_core;
    import ibe_pkg::*;

    // index past the register list, must be dropped by the block
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [KIND_W-1:0]     s_tuser   = KIND_NONE;
    logic                  m_tready  = 1'b1;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_UNIT_TICKS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_ready;

    int                    fail_count;
    int                    pending;
    logic                  eng_idle;
    int                    cmd_count;
    int                    result_count;

    // knobs shared by the sender, the receiver and the SDA model
    int                    gap_odds    = 8;   // 1 in (gap_odds+1) chance of a stall burst
    bit                    quiet       = 1'b0; // no stalls on either side
    int                    sda_low_pct = 50;  // chance that a sampled SDA tick reads low
    int                    ticks_sent  = 0;

    logic [KIND_W-1:0]     cmd_plan[$];

    i2c_master_bit_engine_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    i2c_bit_engine_pin_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_engine_idle  (eng_idle),
        .o_cmd_count    (cmd_count),
        .o_result_count (result_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random bursts of ready held low; always ready when quiet.
    int rx_hold = 0;
    always @(posedge i_clk) begin
        if (!rst_n || quiet) begin
            m_tready <= 1'b1;
            rx_hold = 0;
        end else if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else if ($urandom_range(0, gap_odds) == 0) begin
            m_tready <= 1'b0;
            rx_hold = $urandom_range(1, 16) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic pick_sda();
        return ($urandom_range(1, 100) <= sda_low_pct) ? 1'b0 : 1'b1;
    endfunction

    function automatic bit is_command(input logic [KIND_W-1:0] kind);
        return kind >= KIND_START && kind <= KIND_NACK;
    endfunction

    // One tick transaction. Every task here starts and ends on a rising edge.
    // A stall burst may drop tvalid first; otherwise tvalid stays high so
    // consecutive ticks go back to back.
    task automatic drive_tick(input logic [KIND_W-1:0] kind, input logic [7:0] wdata);
        if (!quiet && $urandom_range(0, gap_odds) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, pick_sda(), wdata};
        do @(posedge i_clk); while (!s_tready);
        ticks_sent++;
    endtask

    // eng_idle read right after an accept reflects every earlier tick, so
    // keep sending empty ticks until the sequencer is back in idle.
    task automatic finish_cmd();
        do drive_tick(KIND_NONE, 8'h00); while (!eng_idle);
    endtask

    task automatic run_cmd(input logic [KIND_W-1:0] kind, input logic [7:0] wdata);
        drive_tick(kind, wdata);
        finish_cmd();
    endtask

    // Idle the input, drain every outstanding result, then cover the
    // pipeline with some slack before touching registers.
    task automatic settle();
        finish_cmd();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Queue up one bus transfer: START, address write, ACK, a few data bytes
    // each way, STOP. Now and then a short stray run of commands instead.
    task automatic plan_transfer();
        int                n;
        logic [KIND_W-1:0] k;
        if ($urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                k = KIND_W'($urandom_range(1, 6));
                cmd_plan.push_back(k);
            end
        end else begin
            cmd_plan.push_back(KIND_START);
            cmd_plan.push_back(KIND_WRITE);
            cmd_plan.push_back(KIND_ACK);
            n = $urandom_range(1, 3);
            repeat (n) begin
                if ($urandom_range(0, 1) == 1) begin
                    cmd_plan.push_back(KIND_WRITE);
                    cmd_plan.push_back(KIND_ACK);
                end else begin
                    cmd_plan.push_back(KIND_READ);
                    if ($urandom_range(0, 1) == 1) cmd_plan.push_back(KIND_NACK);
                end
            end
            cmd_plan.push_back(KIND_STOP);
        end
    endtask

    // Random traffic for about n_ticks ticks. Planned commands go out only
    // when the engine should be idle; stray commands are sprinkled in at random,
    // so some land while it is busy to check that they are dropped (some on the done
    // tick, or just after it).
    task automatic random_traffic(input int n_ticks);
        int                stop_at;
        bit                can_take;
        logic [KIND_W-1:0] k;
        stop_at  = ticks_sent + n_ticks;
        can_take = eng_idle;
        cmd_plan.delete();
        while (ticks_sent < stop_at) begin
            if (cmd_plan.size() == 0) plan_transfer();
            if (can_take && $urandom_range(0, 9) != 0) begin
                k = cmd_plan.pop_front();
            end else if ($urandom_range(0, 9) == 0) begin
                k = KIND_W'($urandom_range(0, 7));
            end else begin
                k = KIND_NONE;
            end
            drive_tick(k, 8'($urandom_range(0, 255)));
            can_take = eng_idle && !is_command(k);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;

        // ---- directed ----
        gap_odds = 6;
        // reset value of unit_ticks (10) on a full NACK
        run_cmd(KIND_NACK, 8'h00);
        settle();

        write_reg(CFG_UNIT_TICKS, 10'd1);
        write_reg(CFG_ACK_LIMIT, 10'd1);
        run_cmd(KIND_START, 8'h00);
        run_cmd(KIND_WRITE, 8'hFF);
        run_cmd(KIND_WRITE, 8'h00);
        sda_low_pct = 0;    // SDA stuck high: ACK check times out
        run_cmd(KIND_ACK, 8'h00);
        run_cmd(KIND_READ, 8'h00);
        sda_low_pct = 100;  // SDA held low: immediate ACK, all-zero byte
        run_cmd(KIND_ACK, 8'h00);
        run_cmd(KIND_READ, 8'h00);
        sda_low_pct = 50;
        run_cmd(KIND_READ, 8'h00);
        run_cmd(KIND_NACK, 8'h00);
        run_cmd(KIND_STOP, 8'h00);
        // NACK runs six ticks at one tick per unit: a WRITE mid-command and a
        // START on the done tick must both be dropped
        drive_tick(KIND_NACK, 8'h00);
        drive_tick(KIND_NONE, 8'h00);
        drive_tick(KIND_WRITE, 8'h5A);
        repeat (3) drive_tick(KIND_NONE, 8'h00);
        drive_tick(KIND_START, 8'h00);
        finish_cmd();
        // reserved kind and no command while idle
        drive_tick(KIND_RSVD, 8'hC3);
        drive_tick(KIND_NONE, 8'h3C);
        settle();

        // zero in either register acts as one; the spare index is ignored
        write_reg(CFG_UNIT_TICKS, 10'd0);
        write_reg(CFG_ACK_LIMIT, 10'd0);
        write_reg(CFG_SPARE, 10'h3FF);
        sda_low_pct = 0;
        run_cmd(KIND_ACK, 8'h00);
        run_cmd(KIND_STOP, 8'h00);
        settle();

        // upper data bits of the limit write are dropped: three polls of SDA high
        write_reg(CFG_UNIT_TICKS, 10'd1);
        write_reg(CFG_ACK_LIMIT, 10'h203);
        run_cmd(KIND_ACK, 8'h00);
        settle();

        // ---- random ----
        write_reg(CFG_UNIT_TICKS, 10'd1);
        write_reg(CFG_ACK_LIMIT, 10'd4);
        gap_odds    = 4;
        sda_low_pct = 30;
        random_traffic(90);
        settle();

        write_reg(CFG_UNIT_TICKS, 10'd2);
        write_reg(CFG_ACK_LIMIT, 10'd1);
        gap_odds    = 16;
        sda_low_pct = 10;
        random_traffic(90);
        settle();

        // widest poll limit, 255 after truncation
        write_reg(CFG_UNIT_TICKS, 10'd1);
        write_reg(CFG_ACK_LIMIT, 10'h3FF);
        gap_odds    = 8;
        sda_low_pct = 25;
        random_traffic(90);
        settle();

        // last stretch runs with no stalls on either side
        write_reg(CFG_UNIT_TICKS, CFG_DATA_W'($urandom_range(1, 2)));
        write_reg(CFG_ACK_LIMIT, CFG_DATA_W'($urandom_range(1, 16)));
        quiet       = 1'b1;
        sda_low_pct = $urandom_range(5, 60);
        random_traffic(90);
        settle();
        repeat (8) @(posedge i_clk);

        $display("tb: %0d ticks sent, %0d commands run by the engine, %0d results checked",
                 ticks_sent, cmd_count, result_count);
        $display("tb: every command kind, dropped and reserved commands, zero and truncated %s",
                 "registers, then random transfers with and without stalls");
        if (pending != 0) $display("tb: %0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ibe_pkg.sv
hw/rtl/ibe_front.sv
hw/rtl/ibe_queue.sv
hw/rtl/ibe_back.sv
hw/rtl/i2c_master_bit_engine_core.sv
hw/rtl/ibe_checker.sv
bench/i2c_bit_engine_pin_checker.sv
bench/tb_i2c_master_bit_engine_core.sv
